// ===== rtl/cfs_pkg.sv =====
package cfs_pkg;

   // Fixed byte codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Register reset values
   localparam logic [7:0] QUOTE_RESET = 8'h22;
   localparam logic [7:0] DELIM_RESET = 8'h2C;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM = 1'b1;

   // Item action codes
   localparam logic ACT_BYTE     = 1'b0;
   localparam logic ACT_LINE_END = 1'b1;

   // Tokeniser state carried between words
   typedef struct packed {
      logic       in_quote;
      logic       quoted_field;
      logic       field_open;
      logic [7:0] held_byte;
      logic       held_valid;
   } cfs_state_type;

   // One result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       record_end;
   } cfs_result_type;

   localparam cfs_state_type STATE_RESET = '{
      in_quote:     1'b0,
      quoted_field: 1'b0,
      field_open:   1'b0,
      held_byte:    8'h00,
      held_valid:   1'b0
   };

endpackage

// ===== rtl/cfs_step.sv =====
module cfs_step (
   input  cfs_pkg::cfs_state_type  state,
   input  logic [7:0]              quote_char,
   input  logic [7:0]              delim_char,
   input  logic                    action,
   input  logic [7:0]              data_byte,
   output cfs_pkg::cfs_state_type  state_next,
   output cfs_pkg::cfs_result_type result,
   output logic                    result_valid
);
   import cfs_pkg::*;

   logic is_quote;
   logic is_delim;
   logic is_crlf;
   logic do_push;
   logic do_close;
   logic close_rec;
   logic [7:0] push_byte;
   logic close_bv;

   // Classify the incoming byte
   assign is_quote = (data_byte == quote_char);
   assign is_delim = (data_byte == delim_char);
   assign is_crlf  = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);

   // Held byte is dropped on close when it is the closing quote of a quoted field
   assign close_bv = state.held_valid &&
                     !(state.quoted_field && (state.held_byte == quote_char));

   // Pick the action for this word
   always_comb begin
      do_push   = 1'b0;
      do_close  = 1'b0;
      close_rec = 1'b0;
      push_byte = data_byte;
      if (action == ACT_LINE_END) begin
         if (state.in_quote) begin
            do_push   = 1'b1;
            push_byte = CHAR_SPACE;
         end else if (state.field_open) begin
            do_close  = 1'b1;
            close_rec = 1'b1;
         end
      end else if (is_quote) begin
         do_push = state.field_open;
      end else if (is_delim && !state.in_quote) begin
         do_close = 1'b1;
      end else if (!(is_crlf && !state.in_quote)) begin
         do_push = 1'b1;
      end
   end

   // Next state and result
   always_comb begin
      state_next        = state;
      result.out_byte   = 8'h00;
      result.byte_valid = 1'b0;
      result.field_end  = 1'b0;
      result.record_end = 1'b0;
      if (action == ACT_LINE_END && !state.in_quote && !state.field_open) begin
         // blank line or line end after a delimiter
         state_next.quoted_field = 1'b0;
         result.record_end       = 1'b1;
      end
      if (action == ACT_BYTE && is_quote) begin
         state_next.in_quote = !state.in_quote;
         if (!state.field_open) begin
            state_next.field_open   = 1'b1;
            state_next.quoted_field = 1'b1;
         end
      end
      if (do_push) begin
         result.byte_valid     = state.held_valid;
         result.out_byte       = state.held_valid ? state.held_byte : 8'h00;
         state_next.held_byte  = push_byte;
         state_next.held_valid = 1'b1;
         state_next.field_open = 1'b1;
      end
      if (do_close) begin
         result.byte_valid = close_bv;
         result.out_byte   = close_bv ? state.held_byte : 8'h00;
         result.field_end  = 1'b1;
         result.record_end = close_rec;
         state_next        = STATE_RESET;
      end
   end

   assign result_valid = result.byte_valid || result.field_end || result.record_end;

endmodule

// ===== rtl/cfs_out_buf.sv =====
module cfs_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cfs_pkg::cfs_result_type push_word,
   output logic                    can_push,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cfs_pkg::cfs_result_type out_word
);
   import cfs_pkg::*;

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   cfs_result_type main_word_ff, main_word_in;
   cfs_result_type skid_word_ff, skid_word_in;
   logic           pop;

   assign pop       = main_valid_ff && out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   // Advance the two-word output stage
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push;
         main_word_in  = push_word;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

// ===== rtl/csv_field_splitter_top.sv =====
// Channel | Dir | Ports             | Word
// req     | in  | req_t*            | tdata: data_byte; tuser: action
// rsp     | out | rsp_t*            | tdata: out_byte; tuser: byte_valid, field_end;
//         |     |                   | tlast: record_end
// csr     | in  | csr_we/index/wdata| 0 quote_char, 1 delim_char
//
// One input word per cycle while req_tready is high; the tokeniser state updates
// in the cycle the word is taken; its result word (if any) is registered onto rsp.
// A two-word output stage keeps req_tready high while one result waits on rsp;
// req_tready drops only when both output words are occupied.
// Synchronous reset clears the tokeniser state, the output stage and restores
// the quote (0x22) and delimiter (0x2C) bytes.
module csv_field_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] field_end
   output logic       rsp_tlast,   // record_end
   input  logic       csr_we,
   input  logic [cfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import cfs_pkg::*;

   logic [7:0]     quote_ff;
   logic [7:0]     delim_ff;
   cfs_state_type  state_ff, state_in;
   cfs_state_type  state_next;
   cfs_result_type step_result;
   cfs_result_type rsp_word;
   logic           step_valid;
   logic           accept;

   assign accept = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= QUOTE_RESET;
         delim_ff <= DELIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUOTE: quote_ff <= csr_wdata;
            CSR_DELIM: delim_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   cfs_step u_step (
      .state        (state_ff),
      .quote_char   (quote_ff),
      .delim_char   (delim_ff),
      .action       (req_tuser),
      .data_byte    (req_tdata),
      .state_next   (state_next),
      .result       (step_result),
      .result_valid (step_valid)
   );

   // Hold state unless a word is taken
   assign state_in = accept ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   cfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_valid),
      .push_word (step_result),
      .can_push  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   assign rsp_tdata    = rsp_word.out_byte;
   assign rsp_tuser[0] = rsp_word.byte_valid;
   assign rsp_tuser[1] = rsp_word.field_end;
   assign rsp_tlast    = rsp_word.record_end;

endmodule

// ===== dv/csv_field_splitter_top_tb.sv =====
module csv_field_splitter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfs_pkg::*;

   localparam int WORDS_PER_PHASE = 125;
   localparam int PHASES          = 8;
   localparam int HOLDOFF_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Idling modes, one per phase in rotation
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One directed word, with its result typed in where it is obvious
   typedef struct packed {
      logic           act;
      logic [7:0]     data;
      logic           typed;
      logic           due;
      cfs_result_type want;
   } directed_row_type;

   localparam cfs_result_type NONE_DUE    = '0;
   localparam cfs_result_type RECORD_ONLY = '{8'h00, 1'b0, 1'b0, 1'b1};
   localparam cfs_result_type FIELD_ONLY  = '{8'h00, 1'b0, 1'b1, 1'b0};

   // Runs with the reset quote (0x22) and delimiter (0x2C)
   localparam directed_row_type DIRECTED [24] = '{
      // blank line straight after reset, then an empty field and its record end
      '{ACT_LINE_END, 8'h00, 1'b1, 1'b1, RECORD_ONLY},
      '{ACT_BYTE,     8'h2C, 1'b1, 1'b1, FIELD_ONLY},
      '{ACT_LINE_END, 8'h00, 1'b1, 1'b1, RECORD_ONLY},
      // quoted field spanning a line end, CR and zero byte kept inside quotes
      '{ACT_BYTE,     8'h22, 1'b1, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h61, 1'b1, 1'b0, NONE_DUE},
      '{ACT_LINE_END, 8'h00, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h0D, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h00, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h22, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h2C, 1'b0, 1'b0, NONE_DUE},
      // bare field with CR/LF dropped and a quote in the middle
      '{ACT_BYTE,     8'hFF, 1'b1, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h0A, 1'b1, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h0D, 1'b1, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h22, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h78, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h22, 1'b0, 1'b0, NONE_DUE},
      '{ACT_LINE_END, 8'h00, 1'b0, 1'b0, NONE_DUE},
      // malformed "ab"c, then a line end right after the delimiter
      '{ACT_BYTE,     8'h22, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h61, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h62, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h22, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h63, 1'b0, 1'b0, NONE_DUE},
      '{ACT_BYTE,     8'h2C, 1'b0, 1'b0, NONE_DUE},
      '{ACT_LINE_END, 8'h00, 1'b1, 1'b1, RECORD_ONLY}
   };

   localparam logic [7:0] QUOTE_SET [PHASES] = '{
      8'h22, 8'h27, 8'h00, 8'hFF, 8'h2C, 8'h0D, 8'h0A, 8'h22
   };
   localparam logic [7:0] DELIM_SET [PHASES] = '{
      8'h2C, 8'h09, 8'hFF, 8'h00, 8'h2C, 8'h0A, 8'h0D, 8'h2C
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tuser = 1'b0;    // [0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [0] byte_valid, [1] field_end
   logic       rsp_tlast;
   logic       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = 8'h00;

   // Tokeniser model state and its copy of the registers
   cfs_state_type  splitter_state = STATE_RESET;
   logic [7:0]     quote_byte     = QUOTE_RESET;
   logic [7:0]     delim_byte     = DELIM_RESET;
   cfs_result_type pending_results [$];
   logic [8:0]     script [$];      // {action, data_byte}

   int error_count   = 0;
   int words_taken   = 0;
   int tx_idle_pct   = 0;
   int rx_stall_pct  = 0;
   int holdoff_asked = 0;
   int holdoff_seen  = 0;
   int holdoff_left  = 0;
   int quiet_cycles  = 0;

   csv_field_splitter_top dut (.*);

   always #5 clock = ~clock;

   // Append one expected result word
   function automatic void queue_result(input cfs_result_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   // Append one stimulus word to the script
   function automatic void queue_step(input logic [8:0] step);
      script.insert(script.size(), step);
   endfunction

   // Advance the tokeniser model by one word; returns 1 when a result word is due
   function automatic logic split_word(input logic act, input logic [7:0] data,
                                       output cfs_result_type res);
      logic       do_push, do_close, close_rec;
      logic       bv, fe, re;
      logic [7:0] push_byte, ob;
      do_push   = 1'b0;
      do_close  = 1'b0;
      close_rec = 1'b0;
      push_byte = data;
      bv = 1'b0;
      fe = 1'b0;
      re = 1'b0;
      ob = 8'h00;
      if (act == ACT_LINE_END) begin
         if (splitter_state.in_quote) begin
            do_push   = 1'b1;
            push_byte = CHAR_SPACE;
         end else if (splitter_state.field_open) begin
            do_close  = 1'b1;
            close_rec = 1'b1;
         end else begin
            splitter_state.quoted_field = 1'b0;
            re = 1'b1;
         end
      end else if (data == quote_byte) begin
         splitter_state.in_quote = !splitter_state.in_quote;
         if (!splitter_state.field_open) begin
            splitter_state.field_open   = 1'b1;
            splitter_state.quoted_field = 1'b1;
         end else begin
            do_push = 1'b1;
         end
      end else if (data == delim_byte && !splitter_state.in_quote) begin
         do_close = 1'b1;
      end else if (!((data == CHAR_CR || data == CHAR_LF) && !splitter_state.in_quote)) begin
         do_push = 1'b1;
      end

      // Pass the content byte through the one-byte delay
      if (do_push) begin
         bv = splitter_state.held_valid;
         ob = splitter_state.held_byte;
         splitter_state.held_byte  = push_byte;
         splitter_state.held_valid = 1'b1;
         splitter_state.field_open = 1'b1;
      end
      // Close the field, dropping a closing quote of a quoted field
      if (do_close) begin
         bv = splitter_state.held_valid &&
              !(splitter_state.quoted_field && splitter_state.held_byte == quote_byte);
         ob = splitter_state.held_byte;
         splitter_state.held_valid   = 1'b0;
         splitter_state.held_byte    = 8'h00;
         splitter_state.quoted_field = 1'b0;
         splitter_state.field_open   = 1'b0;
         splitter_state.in_quote     = 1'b0;
         fe = 1'b1;
         re = close_rec;
      end
      res.out_byte   = bv ? ob : 8'h00;
      res.byte_valid = bv;
      res.field_end  = fe;
      res.record_end = re;
      return bv || fe || re;
   endfunction

   // Random byte biased towards the bytes the tokeniser reacts to
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return quote_byte;
         1: return delim_byte;
         2: return CHAR_CR;
         3: return CHAR_LF;
         4: return 8'h00;
         5: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one word, wait for the handshake, then queue its typed-in or predicted result
   task automatic offer_word(input logic act, input logic [7:0] data, input logic typed,
                             input logic due, input cfs_result_type want);
      cfs_result_type predicted;
      logic           made;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      made = split_word(act, data, predicted);
      if (typed) begin
         if (due) queue_result(want);
      end else if (made) begin
         queue_result(predicted);
      end
      words_taken++;
   endtask

   // Lower valid and let every expected word arrive, plus the pipeline tail
   task automatic await_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_delimiters(input logic [7:0] q, input logic [7:0] d);
      csr_we    <= 1'b1;
      csr_index <= CSR_QUOTE;
      csr_wdata <= q;
      @(posedge clock);
      csr_index <= CSR_DELIM;
      csr_wdata <= d;
      @(posedge clock);
      csr_we     <= 1'b0;
      quote_byte = q;
      delim_byte = d;
   endtask

   // Append one record of random fields, or a burst of noise, to the script
   task automatic compose_chunk();
      int n_fields, len;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 8))
            queue_step({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
         return;
      end
      n_fields = $urandom_range(0, 4);
      for (int f = 0; f < n_fields; f++) begin
         if (f > 0) queue_step({ACT_BYTE, delim_byte});
         len = $urandom_range(0, 5);
         if ($urandom_range(0, 2) == 0) begin
            // quoted field with escaped quotes, delimiters and line ends inside
            queue_step({ACT_BYTE, quote_byte});
            repeat (len) begin
               case ($urandom_range(0, 9))
                  0: begin
                     queue_step({ACT_BYTE, quote_byte});
                     queue_step({ACT_BYTE, quote_byte});
                  end
                  1: queue_step({ACT_LINE_END, 8'($urandom_range(0, 255))});
                  2: queue_step({ACT_BYTE, delim_byte});
                  default: queue_step({ACT_BYTE, pick_byte()});
               endcase
            end
            queue_step({ACT_BYTE, quote_byte});
            // occasionally trail bytes after the closing quote
            if ($urandom_range(0, 7) == 0)
               queue_step({ACT_BYTE, 8'($urandom_range(32, 126))});
         end else begin
            repeat (len) queue_step({ACT_BYTE, 8'($urandom_range(32, 126))});
            if ($urandom_range(0, 9) == 0) queue_step({ACT_BYTE, pick_byte()});
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         queue_step({ACT_BYTE, CHAR_CR});
         queue_step({ACT_BYTE, CHAR_LF});
      end
      queue_step({ACT_LINE_END, 8'($urandom_range(0, 255))});
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned actual);
      if (want != actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, actual);
         error_count++;
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (holdoff_asked != holdoff_seen) begin
         holdoff_seen <= holdoff_asked;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      cfs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %02h/%b/%b/%b",
                     $realtime, rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_byte",   want.out_byte,   rsp_tdata);
            check_field("byte_valid", want.byte_valid, rsp_tuser[0]);
            check_field("field_end",  want.field_end,  rsp_tuser[1]);
            check_field("record_end", want.record_end, rsp_tlast);
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words on the reset register values
      foreach (DIRECTED[i])
         offer_word(DIRECTED[i].act, DIRECTED[i].data, DIRECTED[i].typed,
                    DIRECTED[i].due, DIRECTED[i].want);
      await_drain();

      // Random phases, each with its own delimiters and idling
      for (int p = 0; p < PHASES; p++) begin
         int            phase_start;
         logic          holdoff_done;
         logic [8:0]    w;
         idle_mode_type mode;
         mode = idle_mode_type'(p % 4);
         if (p == PHASES - 1)
            set_delimiters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            set_delimiters(QUOTE_SET[p], DELIM_SET[p]);
         case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 60; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
            default:       begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
         endcase
         phase_start  = words_taken;
         holdoff_done = 1'b0;
         while (words_taken - phase_start < WORDS_PER_PHASE) begin
            compose_chunk();
            while (script.size() != 0) begin
               w = script.pop_front();
               offer_word(w[8], w[7:0], 1'b0, 1'b0, NONE_DUE);
            end
            // hold the receiver off while words keep coming, to back up the input
            if (p == 0 && !holdoff_done && words_taken - phase_start >= 40) begin
               holdoff_asked <= holdoff_asked + 1;
               holdoff_done  = 1'b1;
            end
         end
         await_drain();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
